// ===== sv/assert_macros.svh =====
// assertion helpers shared by the parser modules
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/rfbp_pkg.sv =====
// shared types and constants for the remote-framebuffer server message parser
// used by the front parser, the event queue, the output stage and the top level
package rfbp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_UPD_HDR  = 3'd1,
        PH_RECT_HDR = 3'd2,
        PH_RAW      = 3'd3,
        PH_SKIP     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_PIXEL  = 3'd0,
        EV_RECT   = 3'd1,
        EV_DONE   = 3'd2,
        EV_BELL   = 3'd3,
        EV_BADMSG = 3'd4,
        EV_BADENC = 3'd5,
        EV_SKIP   = 3'd6
    } t_event;

    localparam logic [7:0] MSG_FB_UPDATE  = 8'd0;
    localparam logic [7:0] MSG_COLOUR_MAP = 8'd1;
    localparam logic [7:0] MSG_BELL       = 8'd2;
    localparam logic [7:0] MSG_CUT_TEXT   = 8'd3;

    localparam logic [7:0] CFG_FB_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_FB_HEIGHT = 8'd1;

    localparam logic [3:0] UPD_HDR_LEN  = 4'd3;
    localparam logic [3:0] RECT_HDR_LEN = 4'd12;
    // header byte positions where each rectangle field ends
    localparam logic [3:0] LEFT_END     = 4'd2;
    localparam logic [3:0] TOP_END      = 4'd4;
    localparam logic [3:0] WIDTH_END    = 4'd6;
    localparam logic [3:0] HEIGHT_END   = 4'd8;

    // one queue word: a primary event, optionally followed by update done
    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [33:0] offset;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic        has_done;
    } t_entry;

endpackage

// ===== sv/rfb_server_message_parser.sv =====
// remote-framebuffer server message parser, one stream byte per cycle while the queue has room
// a result word passes through the event queue and then the output register
// throughput: one byte per cycle while the queue has room; a byte that yields two
//   results (last pixel or empty rectangle, then update done) yields two output words
// reset: synchronous active low, parser idle, queue empty, size registers zero
module rfb_server_message_parser
    import rfbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [33:0] o_byte_offset,
    output logic [15:0] o_rect_left,
    output logic [15:0] o_rect_top,
    output logic [15:0] o_rect_width,
    output logic [15:0] o_rect_height,
    output logic [15:0] o_req_width,
    output logic [15:0] o_req_height,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic   room, push, head_valid, pop;
    t_entry entry, head;

    assign o_cfg_ready = 1'b1;

    rfbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .o_in_ready (o_in_ready),
        .i_room     (room),
        .o_push     (push),
        .o_entry    (entry)
    );

    rfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .o_room       (room),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    rfbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_res   (o_event_res),
        .o_data_byte   (o_data_byte),
        .o_byte_offset (o_byte_offset),
        .o_rect_left   (o_rect_left),
        .o_rect_top    (o_rect_top),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height),
        .o_req_width   (o_req_width),
        .o_req_height  (o_req_height),
        .o_last        (o_last)
    );

endmodule

// ===== sv/rfbp_front.sv =====
// front parser: takes one stream byte per cycle while the queue has room, tracks header
// and raw state and pushes classified event words into the queue; uses rfbp_pkg
`include "assert_macros.svh"
module rfbp_front
    import rfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_in_byte,
    output logic        o_in_ready,
    input  logic        i_room,
    output logic        o_push,
    output t_entry      o_entry
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_rects, n_rects;
    logic [15:0] r_left, n_left;
    logic [15:0] r_top, n_top;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_enc, n_enc;
    logic [33:0] r_raw_left, n_raw_left;
    logic [33:0] r_raw_off, n_raw_off;
    logic [31:0] r_area;
    logic        accept;
    logic [3:0]  idx_inc;
    logic [15:0] rects_dec;

    assign o_in_ready = i_room;
    assign accept     = i_in_valid && i_room;
    assign idx_inc    = r_idx + 4'd1;
    assign rects_dec  = r_rects - 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_rects    = r_rects;
        n_left     = r_left;
        n_top      = r_top;
        n_width    = r_width;
        n_height   = r_height;
        n_enc      = r_enc;
        n_raw_left = r_raw_left;
        n_raw_off  = r_raw_off;
        o_push     = 1'b0;
        o_entry.ev       = EV_PIXEL;
        o_entry.data     = 8'd0;
        o_entry.offset   = 34'd0;
        o_entry.left     = r_left;
        o_entry.top      = r_top;
        o_entry.width    = r_width;
        o_entry.height   = r_height;
        o_entry.has_done = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_UPD_HDR: begin
                    // first header byte is padding
                    if (r_idx != 4'd0) n_rects = {r_rects[7:0], i_in_byte};
                    if (idx_inc >= UPD_HDR_LEN) begin
                        n_idx   = 4'd0;
                        n_phase = PH_RECT_HDR;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
                PH_RECT_HDR: begin
                    if (r_idx < LEFT_END)        n_left   = {r_left[7:0], i_in_byte};
                    else if (r_idx < TOP_END)    n_top    = {r_top[7:0], i_in_byte};
                    else if (r_idx < WIDTH_END)  n_width  = {r_width[7:0], i_in_byte};
                    else if (r_idx < HEIGHT_END) n_height = {r_height[7:0], i_in_byte};
                    else                         n_enc    = {r_enc[23:0], i_in_byte};
                    if (idx_inc >= RECT_HDR_LEN) begin
                        n_idx  = 4'd0;
                        o_push = 1'b1;
                        if (n_enc == 32'd0) begin
                            o_entry.ev = EV_RECT;
                            n_raw_left = {r_area, 2'b00};
                            n_raw_off  = 34'd0;
                            if (r_area == 32'd0) begin
                                // empty rectangle completes on the same byte
                                n_rects          = rects_dec;
                                o_entry.has_done = (rects_dec == 16'd0);
                                n_phase = (rects_dec == 16'd0) ? PH_IDLE : PH_RECT_HDR;
                            end else begin
                                n_phase = PH_RAW;
                            end
                        end else begin
                            o_entry.ev = EV_BADENC;
                            n_phase    = PH_IDLE;
                        end
                    end else begin
                        n_idx = idx_inc;
                    end
                end
                PH_RAW: begin
                    o_push         = 1'b1;
                    o_entry.ev     = EV_PIXEL;
                    o_entry.data   = i_in_byte;
                    o_entry.offset = r_raw_off;
                    n_raw_off      = r_raw_off + 34'd1;
                    n_raw_left     = r_raw_left - 34'd1;
                    if (r_raw_left == 34'd1) begin
                        n_idx            = 4'd0;
                        n_rects          = rects_dec;
                        o_entry.has_done = (rects_dec == 16'd0);
                        n_phase = (rects_dec == 16'd0) ? PH_IDLE : PH_RECT_HDR;
                    end
                end
                PH_SKIP: begin
                    o_push     = 1'b1;
                    o_entry.ev = EV_SKIP;
                    n_phase    = PH_IDLE;
                end
                default: begin
                    n_idx = 4'd0;
                    unique case (i_in_byte) inside
                        MSG_FB_UPDATE: n_phase = PH_UPD_HDR;
                        MSG_COLOUR_MAP, MSG_CUT_TEXT: n_phase = PH_SKIP;
                        MSG_BELL: begin
                            o_push     = 1'b1;
                            o_entry.ev = EV_BELL;
                            n_phase    = PH_IDLE;
                        end
                        default: begin
                            o_push     = 1'b1;
                            o_entry.ev = EV_BADMSG;
                            n_phase    = PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_idx      <= 4'd0;
            r_rects    <= 16'd0;
            r_left     <= 16'd0;
            r_top      <= 16'd0;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_enc      <= 32'd0;
            r_raw_left <= 34'd0;
            r_raw_off  <= 34'd0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_rects    <= n_rects;
            r_left     <= n_left;
            r_top      <= n_top;
            r_width    <= n_width;
            r_height   <= n_height;
            r_enc      <= n_enc;
            r_raw_left <= n_raw_left;
            r_raw_off  <= n_raw_off;
        end
    end

    // area is formed while the encoding bytes arrive, width and height are final by then
    always_ff @(posedge i_clk) begin
        if (accept && r_phase == PH_RECT_HDR && r_idx == HEIGHT_END) begin
            r_area <= 32'(r_width) * 32'(r_height);
        end
    end

    `ASSERT_IMPLIES(a_raw_nonempty, r_phase == PH_RAW, r_raw_left != 34'd0,
        "raw phase with no pixel bytes left")

endmodule

// ===== sv/rfbp_queue.sv =====
// short event queue between the front parser and the output stage
// register array with read and write pointers; uses rfbp_pkg for the word type
`include "assert_macros.svh"
module rfbp_queue
    import rfbp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_room,
    output logic   o_head_valid,
    output t_entry o_head,
    input  logic   i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_room       = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) n_count = r_count + CW'(1);
        else if (!i_push && i_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    `ASSERT_IMPLIES(a_no_overflow, i_push && !i_pop, r_count != CW'(DEPTH),
        "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_pop, r_count != '0,
        "pop from an empty queue")

endmodule

// ===== sv/rfbp_back.sv =====
// output stage: expands queue words into result words and holds the
// framebuffer size registers for the update request; uses rfbp_pkg
`include "assert_macros.svh"
module rfbp_back
    import rfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [33:0] o_byte_offset,
    output logic [15:0] o_rect_left,
    output logic [15:0] o_rect_top,
    output logic [15:0] o_rect_width,
    output logic [15:0] o_rect_height,
    output logic [15:0] o_req_width,
    output logic [15:0] o_req_height,
    output logic        o_last
);

    logic [15:0] r_fb_width, r_fb_height;
    logic        r_out_valid;
    logic        r_half;      // primary event of the head word already sent
    t_event      r_ev;
    logic [7:0]  r_data;
    logic [33:0] r_off;
    logic [15:0] r_left, r_top, r_width, r_height;
    logic [15:0] r_req_w, r_req_h;
    logic        r_last;
    logic        can_load;
    logic        load;
    t_event      sel_ev;

    assign can_load = !r_out_valid || i_out_ready;
    assign load     = can_load && i_head_valid;
    assign o_pop    = load && (!i_head.has_done || r_half);
    assign sel_ev   = r_half ? EV_DONE : i_head.ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= 16'd0;
            r_fb_height <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) r_half <= !r_half && i_head.has_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev     <= sel_ev;
            r_data   <= r_half ? 8'd0 : i_head.data;
            r_off    <= r_half ? 34'd0 : i_head.offset;
            r_left   <= i_head.left;
            r_top    <= i_head.top;
            r_width  <= i_head.width;
            r_height <= i_head.height;
            r_req_w  <= (sel_ev == EV_DONE) ? r_fb_width : 16'd0;
            r_req_h  <= (sel_ev == EV_DONE) ? r_fb_height : 16'd0;
            r_last   <= r_half || !i_head.has_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_ev;
    assign o_data_byte   = r_data;
    assign o_byte_offset = r_off;
    assign o_rect_left   = r_left;
    assign o_rect_top    = r_top;
    assign o_rect_width  = r_width;
    assign o_rect_height = r_height;
    assign o_req_width   = r_req_w;
    assign o_req_height  = r_req_h;
    assign o_last        = r_last;

    `ASSERT_IMPLIES(a_half_has_word, r_half, i_head_valid && i_head.has_done && r_out_valid,
        "second event pending without its queue word")

endmodule
